// ===== sv/fra_pkg.sv =====
// Shared types, codes and a helper function of the flow record aggregator.
package fra_pkg;

  typedef struct packed {
    logic        op;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] src_port_in;
    logic [15:0] dst_port_in;
    logic [63:0] packet_count;
    logic [63:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] packet_total;
    logic [63:0] byte_total;
    logic        overflow;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] packet_sum;
    logic [63:0] byte_sum;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCAN,
    ST_EMIT
  } state_t;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_DUMP  = 1'b1;

  localparam logic [2:0] KS_SRC_ADDR = 3'd0;
  localparam logic [2:0] KS_SRC_V4   = 3'd1;
  localparam logic [2:0] KS_SRC_V6   = 3'd2;
  localparam logic [2:0] KS_DST_ADDR = 3'd3;
  localparam logic [2:0] KS_DST_V4   = 3'd4;
  localparam logic [2:0] KS_DST_V6   = 3'd5;
  localparam logic [2:0] KS_SRC_PORT = 3'd6;
  localparam logic [2:0] KS_DST_PORT = 3'd7;

  localparam logic [1:0] CFG_KEY_SELECT = 2'd0;
  localparam logic [1:0] CFG_PREFIX_LEN = 2'd1;
  localparam logic [1:0] CFG_SORT_BY    = 2'd2;

  localparam logic [7:0] IPV4_BITS = 8'd32;
  localparam logic [7:0] HALF_BITS = 8'd64;
  localparam logic [7:0] ADDR_BITS = 8'd128;

  // Mask that keeps the n leading bits of a 64-bit word.
  function automatic logic [63:0] lead_mask64(input logic [7:0] n);
    logic [63:0] m;
    m = '1;
    if (n == 8'd0) begin
      m = '0;
    end else if (n < HALF_BITS) begin
      m = m << (HALF_BITS - n);
    end
    return m;
  endfunction

endpackage

// ===== sv/fra_if.sv =====
// Valid/ready channel interfaces for flow records and dump results.
interface fra_in_if;
  logic               valid;
  logic               ready;
  fra_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fra_out_if;
  logic               valid;
  logic               ready;
  fra_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/flow_record_aggregator_top.sv =====
// Flow record aggregator: keyed table with summing and a sorted dump.
//
// Records arrive on in_ch, dump results leave on out_ch; both are valid/ready
// channels and a transaction happens when valid and ready are both high.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user is to
// write it only while idle, and the block itself does not enforce this.
// The block holds one item at a time: in_ch.ready is high only when idle.
// An accumulate record walks the table memory one entry per cycle through
// its single read port. A dump runs one selection pass over the table for each
// emitted entry. An empty table dump gives one result with entry_valid low.
// Results sit in an output register; while the receiver stalls the block
// holds the result and starts no further pass.
// Reset clears the entry count, the overflow flag, the state and the
// configuration to their defaults; the table memory itself needs no clearing.
module flow_record_aggregator_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  fra_in_if.sink           in_ch,
  fra_out_if.source        out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  logic [2:0] key_select;
  logic [7:0] prefix_len;
  logic       sort_by;

  fra_pkg::state_t state, state_next;

  logic [CW-1:0]   entry_count;
  logic            dropped_flag;
  logic [63:0]     cur_kh;
  logic [63:0]     cur_kl;
  logic [63:0]     cur_pkt;
  logic [63:0]     cur_byt;
  logic [CW-1:0]   issue;
  logic            rvalid;
  logic [AW-1:0]   ridx;
  logic [CW-1:0]   pos;
  logic            has_prev;
  logic [191:0]    prev_tuple;
  logic            best_valid;
  fra_pkg::entry_t best;
  fra_pkg::out_item_t out_reg;

  logic [63:0]     key_kh;
  logic [63:0]     key_kl;
  logic            accept;
  logic            taken;
  logic            match;
  logic            hit;
  logic            at_last;
  logic            miss_done;
  logic            scan_done;
  logic [AW-1:0]   last_idx;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  fra_pkg::entry_t mem_wdata;
  logic            mem_re;
  fra_pkg::entry_t rdata;
  logic [191:0]    rd_tuple;
  logic [191:0]    best_tuple;
  logic            take_rd;
  fra_pkg::entry_t best_next;

  fra_key u_key (
    .item       (in_ch.data),
    .key_select (key_select),
    .prefix_len (prefix_len),
    .key_high   (key_kh),
    .key_low    (key_kl)
  );

  fra_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (issue[AW-1:0]),
    .rdata (rdata)
  );

  assign accept    = in_ch.valid && in_ch.ready;
  assign taken     = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (state == fra_pkg::ST_IDLE);
  assign out_ch.valid = (state == fra_pkg::ST_EMIT);
  assign out_ch.data  = out_reg;

  assign last_idx  = AW'(entry_count - CW'(1));
  assign at_last   = rvalid && (ridx == last_idx);
  assign match     = (rdata.key_high == cur_kh) && (rdata.key_low == cur_kl);
  assign hit       = (state == fra_pkg::ST_SEARCH) && rvalid && match;
  assign miss_done = (state == fra_pkg::ST_SEARCH) && !hit &&
                     ((entry_count == '0) || at_last);
  assign scan_done = (state == fra_pkg::ST_SCAN) && at_last;

  // Selection pass: keep the largest entry that sorts after the last one sent.
  always_comb begin
    rd_tuple   = {sort_by ? rdata.byte_sum : rdata.packet_sum,
                  rdata.key_high, rdata.key_low};
    best_tuple = {sort_by ? best.byte_sum : best.packet_sum,
                  best.key_high, best.key_low};
    take_rd    = rvalid && (!has_prev || (rd_tuple < prev_tuple)) &&
                 (!best_valid || (rd_tuple > best_tuple));
    best_next  = take_rd ? rdata : best;
  end

  always_comb begin
    state_next = state;
    case (state)
      fra_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.data.op == fra_pkg::OP_DUMP) begin
            state_next = (entry_count == '0) ? fra_pkg::ST_EMIT : fra_pkg::ST_SCAN;
          end else begin
            state_next = fra_pkg::ST_SEARCH;
          end
        end
      end
      fra_pkg::ST_SEARCH: begin
        if (hit || miss_done) begin
          state_next = fra_pkg::ST_IDLE;
        end
      end
      fra_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = fra_pkg::ST_EMIT;
        end
      end
      fra_pkg::ST_EMIT: begin
        if (taken) begin
          state_next = out_reg.last ? fra_pkg::ST_IDLE : fra_pkg::ST_SCAN;
        end
      end
      default: state_next = fra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_re    = ((state == fra_pkg::ST_SEARCH) || (state == fra_pkg::ST_SCAN)) &&
                (issue < entry_count) && !hit;
    mem_we    = 1'b0;
    mem_waddr = ridx;
    mem_wdata = rdata;
    if (hit) begin
      mem_we               = 1'b1;
      mem_waddr            = ridx;
      mem_wdata.packet_sum = rdata.packet_sum + cur_pkt;
      mem_wdata.byte_sum   = rdata.byte_sum + cur_byt;
    end else if (miss_done && (entry_count != FULL)) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(entry_count);
      mem_wdata = '{key_high: cur_kh, key_low: cur_kl,
                    packet_sum: cur_pkt, byte_sum: cur_byt};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fra_pkg::ST_IDLE;
      key_select   <= 3'd0;
      prefix_len   <= 8'd32;
      sort_by      <= 1'b0;
      entry_count  <= '0;
      dropped_flag <= 1'b0;
      rvalid       <= 1'b0;
      issue        <= '0;
      pos          <= '0;
      has_prev     <= 1'b0;
      best_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= mem_re;
      if (cfg_we) begin
        case (cfg_index)
          fra_pkg::CFG_KEY_SELECT: key_select <= cfg_data[2:0];
          fra_pkg::CFG_PREFIX_LEN: prefix_len <= cfg_data;
          fra_pkg::CFG_SORT_BY:    sort_by    <= cfg_data[0];
          default: ;
        endcase
      end
      if (mem_re) begin
        issue <= issue + CW'(1);
      end
      if (accept) begin
        issue      <= '0;
        pos        <= '0;
        has_prev   <= 1'b0;
        best_valid <= 1'b0;
      end
      if (miss_done) begin
        if (entry_count != FULL) begin
          entry_count <= entry_count + CW'(1);
        end else begin
          dropped_flag <= 1'b1;
        end
      end
      if (state == fra_pkg::ST_SCAN && take_rd) begin
        best_valid <= 1'b1;
      end
      if (taken && !out_reg.last) begin
        issue      <= '0;
        pos        <= pos + CW'(1);
        has_prev   <= 1'b1;
        best_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      ridx <= issue[AW-1:0];
    end
    if (accept) begin
      cur_kh  <= key_kh;
      cur_kl  <= key_kl;
      cur_pkt <= in_ch.data.packet_count;
      cur_byt <= in_ch.data.byte_count;
      out_reg <= '{entry_valid: 1'b0, key_high: '0, key_low: '0,
                   packet_total: '0, byte_total: '0,
                   overflow: dropped_flag, last: 1'b1};
    end
    if (state == fra_pkg::ST_SCAN) begin
      best <= best_next;
    end
    if (scan_done) begin
      out_reg <= '{entry_valid: 1'b1, key_high: best_next.key_high,
                   key_low: best_next.key_low,
                   packet_total: best_next.packet_sum,
                   byte_total: best_next.byte_sum,
                   overflow: dropped_flag,
                   last: (pos + CW'(1)) == entry_count};
    end
    if (taken) begin
      prev_tuple <= {sort_by ? out_reg.byte_total : out_reg.packet_total,
                     out_reg.key_high, out_reg.key_low};
    end
  end

endmodule

// ===== sv/fra_key.sv =====
// Forms the 128-bit aggregation key of a flow record.
module fra_key (
  input  fra_pkg::in_item_t item,
  input  logic [2:0]        key_select,
  input  logic [7:0]        prefix_len,
  output logic [63:0]       key_high,
  output logic [63:0]       key_low
);

  logic [7:0]  p4;
  logic [7:0]  p6;
  logic [7:0]  p6_high;
  logic [7:0]  p6_low;
  logic [63:0] m4;
  logic [63:0] mh;
  logic [63:0] ml;
  logic        use_dst;
  logic [63:0] ah;
  logic [63:0] al;

  always_comb begin
    p4      = (prefix_len > fra_pkg::IPV4_BITS) ? fra_pkg::IPV4_BITS : prefix_len;
    p6      = (prefix_len > fra_pkg::ADDR_BITS) ? fra_pkg::ADDR_BITS : prefix_len;
    p6_high = (p6 > fra_pkg::HALF_BITS) ? fra_pkg::HALF_BITS : p6;
    p6_low  = (p6 > fra_pkg::HALF_BITS) ? (p6 - fra_pkg::HALF_BITS) : 8'd0;
    m4      = fra_pkg::lead_mask64(p4);
    mh      = fra_pkg::lead_mask64(p6_high);
    ml      = fra_pkg::lead_mask64(p6_low);
    use_dst = (key_select inside {fra_pkg::KS_DST_ADDR, fra_pkg::KS_DST_V4,
                                  fra_pkg::KS_DST_V6});
    ah      = use_dst ? item.dst_addr_high : item.src_addr_high;
    al      = use_dst ? item.dst_addr_low : item.src_addr_low;
    case (key_select)
      fra_pkg::KS_SRC_V4, fra_pkg::KS_DST_V4: begin
        key_high = '0;
        key_low  = {32'd0, al[31:0] & m4[63:32]};
      end
      fra_pkg::KS_SRC_V6, fra_pkg::KS_DST_V6: begin
        key_high = ah & mh;
        key_low  = al & ml;
      end
      fra_pkg::KS_SRC_PORT: begin
        key_high = '0;
        key_low  = {48'd0, item.src_port_in};
      end
      fra_pkg::KS_DST_PORT: begin
        key_high = '0;
        key_low  = {48'd0, item.dst_port_in};
      end
      default: begin
        key_high = ah;
        key_low  = al;
      end
    endcase
  end

endmodule

// ===== sv/fra_mem.sv =====
// Entry table: one write port and one registered read port.
module fra_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  fra_pkg::entry_t  wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output fra_pkg::entry_t  rdata
);

  fra_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench for the flow record aggregator: random records, sorted dumps, self-checking.
module tb_top;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_ITEMS = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  fra_in_if in_ch ();
  fra_out_if out_ch ();

  flow_record_aggregator_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  class flow_table_scoreboard;
    logic [2:0] key_sel;
    logic [7:0] pfx_len;
    logic order_by_bytes;
    logic [63:0] key_hi[DEPTH];
    logic [63:0] key_lo[DEPTH];
    logic [63:0] pkt_sum[DEPTH];
    logic [63:0] byte_sum[DEPTH];
    int entries;
    logic dropped;
    fra_pkg::out_item_t dump_rows[$];
    int mismatches;
    int results_seen;
    int dumps_seen;
    int overflow_dumps;

    function new();
      key_sel = fra_pkg::KS_SRC_ADDR;
      pfx_len = fra_pkg::IPV4_BITS;
      order_by_bytes = 1'b0;
      entries = 0;
      dropped = 1'b0;
      mismatches = 0;
      results_seen = 0;
      dumps_seen = 0;
      overflow_dumps = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        fra_pkg::CFG_KEY_SELECT: key_sel = val[2:0];
        fra_pkg::CFG_PREFIX_LEN: pfx_len = val;
        fra_pkg::CFG_SORT_BY: order_by_bytes = val[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] head_bits(int n);
      if (n <= 0) return 64'd0;
      if (n >= 64) return '1;
      return ~64'd0 << (64 - n);
    endfunction

    function void form_key(fra_pkg::in_item_t it, output logic [63:0] kh,
                           output logic [63:0] kl);
      logic from_dst;
      logic [63:0] ah;
      logic [63:0] al;
      logic [63:0] m4;
      int p;
      from_dst = (key_sel == fra_pkg::KS_DST_ADDR) || (key_sel == fra_pkg::KS_DST_V4) ||
                 (key_sel == fra_pkg::KS_DST_V6);
      ah = from_dst ? it.dst_addr_high : it.src_addr_high;
      al = from_dst ? it.dst_addr_low : it.src_addr_low;
      case (key_sel)
        fra_pkg::KS_SRC_V4, fra_pkg::KS_DST_V4: begin
          p = (pfx_len > 32) ? 32 : int'(pfx_len);
          m4 = head_bits(p);
          kh = 64'd0;
          kl = al & {32'd0, m4[63:32]};
        end
        fra_pkg::KS_SRC_V6, fra_pkg::KS_DST_V6: begin
          p = (pfx_len > 128) ? 128 : int'(pfx_len);
          kh = ah & head_bits(p > 64 ? 64 : p);
          kl = al & ((p > 64) ? head_bits(p - 64) : 64'd0);
        end
        fra_pkg::KS_SRC_PORT: begin
          kh = 64'd0;
          kl = {48'd0, it.src_port_in};
        end
        fra_pkg::KS_DST_PORT: begin
          kh = 64'd0;
          kl = {48'd0, it.dst_port_in};
        end
        default: begin
          kh = ah;
          kl = al;
        end
      endcase
    endfunction

    function bit ranks_above(int a, int b);
      logic [63:0] ca;
      logic [63:0] cb;
      ca = order_by_bytes ? byte_sum[a] : pkt_sum[a];
      cb = order_by_bytes ? byte_sum[b] : pkt_sum[b];
      if (ca != cb) return ca > cb;
      if (key_hi[a] != key_hi[b]) return key_hi[a] > key_hi[b];
      return key_lo[a] > key_lo[b];
    endfunction

    // Called for every accepted input transaction.
    function void note_input(fra_pkg::in_item_t it);
      logic [63:0] kh;
      logic [63:0] kl;
      int rank[DEPTH];
      int j;
      int v;
      fra_pkg::out_item_t row;
      if (it.op == fra_pkg::OP_ACCUM) begin
        form_key(it, kh, kl);
        for (int i = 0; i < entries; i++) begin
          if (key_hi[i] == kh && key_lo[i] == kl) begin
            pkt_sum[i] += it.packet_count;
            byte_sum[i] += it.byte_count;
            return;
          end
        end
        if (entries < DEPTH) begin
          key_hi[entries] = kh;
          key_lo[entries] = kl;
          pkt_sum[entries] = it.packet_count;
          byte_sum[entries] = it.byte_count;
          entries++;
        end else begin
          dropped = 1'b1;
        end
        return;
      end
      dumps_seen++;
      if (dropped) overflow_dumps++;
      if (entries == 0) begin
        row = '0;
        row.overflow = dropped;
        row.last = 1'b1;
        dump_rows.insert(dump_rows.size(), row);
        return;
      end
      for (int i = 0; i < entries; i++) begin
        v = i;
        j = i;
        while (j > 0 && ranks_above(v, rank[j-1])) begin
          rank[j] = rank[j-1];
          j--;
        end
        rank[j] = v;
      end
      for (int i = 0; i < entries; i++) begin
        row.entry_valid = 1'b1;
        row.key_high = key_hi[rank[i]];
        row.key_low = key_lo[rank[i]];
        row.packet_total = pkt_sum[rank[i]];
        row.byte_total = byte_sum[rank[i]];
        row.overflow = dropped;
        row.last = (i == entries - 1);
        dump_rows.insert(dump_rows.size(), row);
      end
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", what);
    endfunction

    // Called for every accepted output transaction.
    function void check_result(fra_pkg::out_item_t got);
      fra_pkg::out_item_t want;
      results_seen++;
      if (dump_rows.size() == 0) begin
        report($sformatf("unexpected result key=%h_%h", got.key_high, got.key_low));
        return;
      end
      want = dump_rows.pop_front();
      if (got.entry_valid !== want.entry_valid)
        report($sformatf("entry_valid exp %b got %b", want.entry_valid, got.entry_valid));
      if (got.key_high !== want.key_high)
        report($sformatf("key_high exp %h got %h", want.key_high, got.key_high));
      if (got.key_low !== want.key_low)
        report($sformatf("key_low exp %h got %h", want.key_low, got.key_low));
      if (got.packet_total !== want.packet_total)
        report($sformatf("packet_total exp %h got %h", want.packet_total, got.packet_total));
      if (got.byte_total !== want.byte_total)
        report($sformatf("byte_total exp %h got %h", want.byte_total, got.byte_total));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow exp %b got %b", want.overflow, got.overflow));
      if (got.last !== want.last)
        report($sformatf("last exp %b got %b", want.last, got.last));
    endfunction
  endclass

  flow_table_scoreboard flow_sb;

  logic [63:0] addr_pool[16];
  logic [15:0] port_pool[8];
  int burst_left;
  int stall_left;
  int hold_left;
  bit hold_request;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor and watchdog: sample both channels at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) flow_sb.note_input(in_ch.data);
      if (out_ch.valid && out_ch.ready) flow_sb.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: a random stall pattern, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_request && hold_left == 0) begin
      hold_request = 1'b0;
      hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          stall_left <= $urandom_range(1, 8);
          out_ch.ready <= 1'b0;
        end
        1, 2: out_ch.ready <= 1'b0;
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    flow_sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(fra_pkg::in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(0, 8);
    end
  endtask

  // Lowers valid, waits until every dump row has arrived and the hold-off is over, then lets the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (flow_sb.dump_rows.size() != 0 || hold_left != 0 || hold_request) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_addr();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return addr_pool[$urandom_range(0, 15)];
  endfunction

  function automatic logic [63:0] pick_count();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return {$urandom, $urandom};
      2: return ~64'd0 - 64'($urandom_range(0, 50));
      default: return 64'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic fra_pkg::in_item_t rand_record(bit dump);
    fra_pkg::in_item_t it;
    it.op = dump ? fra_pkg::OP_DUMP : fra_pkg::OP_ACCUM;
    it.src_addr_high = pick_addr();
    it.src_addr_low = pick_addr();
    it.dst_addr_high = pick_addr();
    it.dst_addr_low = pick_addr();
    it.src_port_in = ($urandom_range(0, 3) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 7)];
    it.dst_port_in = ($urandom_range(0, 3) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 7)];
    it.packet_count = pick_count();
    it.byte_count = pick_count();
    return it;
  endfunction

  initial begin
    fra_pkg::in_item_t it;
    logic [2:0] ks_list[12] = '{fra_pkg::KS_SRC_ADDR, fra_pkg::KS_SRC_V4, fra_pkg::KS_SRC_V4,
                                fra_pkg::KS_SRC_V6, fra_pkg::KS_SRC_V6, fra_pkg::KS_SRC_V6,
                                fra_pkg::KS_DST_ADDR, fra_pkg::KS_DST_V4, fra_pkg::KS_DST_V6,
                                fra_pkg::KS_SRC_PORT, fra_pkg::KS_DST_PORT,
                                fra_pkg::KS_SRC_V6};
    logic [7:0] pl_list[12] = '{8'd32, 8'd0, 8'd255, 8'd64, 8'd65, 8'd128,
                                8'd7, 8'd17, 8'd100, 8'd1, 8'd200, 8'd0};
    int items_per_phase;

    flow_sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= fra_pkg::CFG_KEY_SELECT;
    cfg_data <= 8'd0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    hold_request = 1'b0;
    quiet_cycles = 0;
    burst_left = 0;
    foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
    foreach (port_pool[i]) port_pool[i] = 16'($urandom);
    port_pool[0] = 16'hFFFF;
    port_pool[1] = 16'h0000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dump, extreme fields, counter wrap, a tie on counts.
    it = '0;
    it.op = fra_pkg::OP_DUMP;
    send_item(it);
    it = '0;
    send_item(it);
    it = '1;
    it.op = fra_pkg::OP_ACCUM;
    send_item(it);
    send_item(it);
    it = '0;
    it.src_addr_low = 64'h1;
    it.packet_count = 64'd5;
    it.byte_count = 64'd9;
    send_item(it);
    it.src_addr_high = 64'h1;
    send_item(it);
    it.op = fra_pkg::OP_DUMP;
    send_item(it);
    drain();
    write_reg(fra_pkg::CFG_SORT_BY, 8'hFF);
    write_reg(2'd3, 8'hA5);
    it.op = fra_pkg::OP_DUMP;
    send_item(it);
    drain();

    items_per_phase = RANDOM_ITEMS / 12;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(fra_pkg::CFG_KEY_SELECT, {5'($urandom), ks_list[ph]});
      write_reg(fra_pkg::CFG_PREFIX_LEN, pl_list[ph]);
      write_reg(fra_pkg::CFG_SORT_BY, {7'($urandom), ph[0]});
      for (int n = 0; n < items_per_phase; n++) begin
        // One long receiver hold-off while records keep coming behind a dump.
        if (ph == 4 && n == 5) begin
          hold_request = 1'b1;
          send_item(rand_record(1'b1));
        end else begin
          send_item(rand_record($urandom_range(0, 11) == 0));
        end
      end
      send_item(rand_record(1'b1));
      drain();
    end

    drain();
    $display("Checked %0d dump rows from %0d dumps over all eight key modes and both orders.",
             flow_sb.results_seen, flow_sb.dumps_seen);
    $display("Table held %0d entries; %0d dumps saw the overflow flag set.",
             flow_sb.entries, flow_sb.overflow_dumps);
    if (flow_sb.mismatches == 0 && flow_sb.dump_rows.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d rows never arrived", flow_sb.mismatches,
               flow_sb.dump_rows.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fra_pkg.sv
sv/fra_if.sv
sv/fra_key.sv
sv/fra_mem.sv
sv/flow_record_aggregator_top.sv
test/tb_top.sv
